### rtl/core/text_mode_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text mode console writer
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TMCW_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define TMCW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define TMCW_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define TMCW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

### rtl/core/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// Text mode console writer package
// Screen geometry, field types, command codes and the decoded operation word.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// Screen geometry.
	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELLS         = ROWS * COLUMNS;
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W        = $clog2(CELLS);
	localparam int ROW_W         = $clog2(ROWS);
	localparam int COL_W         = $clog2(COLUMNS);

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Internal types.
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	// Port field types.
	typedef logic [2:0]  command_t;
	typedef logic [7:0]  char_t;
	typedef logic [7:0]  attr_t;
	typedef logic [4:0]  trow_t;
	typedef logic [6:0]  tcol_t;
	typedef logic [10:0] pos_t;
	typedef logic [15:0] cell_t;

	// Characters and the reset attribute.
	localparam attr_t RESET_ATTR = 8'h0F;
	localparam char_t CH_NEWLINE = 8'd10;
	localparam char_t CH_RETURN  = 8'd13;
	localparam char_t CH_SPACE   = 8'h20;

	// Command codes on the input word.
	localparam command_t CMD_PUT       = 3'd0;
	localparam command_t CMD_BACKSPACE = 3'd1;
	localparam command_t CMD_CLEAR     = 3'd2;
	localparam command_t CMD_WRITE_AT  = 3'd3;
	localparam command_t CMD_READ      = 3'd4;

	// Operation classes produced by the front.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_WRITE,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		char_t    ch;
		attr_t    color;
		addr_t    addr;
		logic     echo;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic init;
		logic busy;
	} back_stat_t;

endpackage

### rtl/core/tmcw_if.sv
// ----------------------------------------------------------------------------
// Text mode console writer channels
// Command channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface tmcw_cmd_if;
	logic               valid;
	logic               ready;
	tmcw_pkg::command_t command;
	tmcw_pkg::char_t    char_code;
	tmcw_pkg::trow_t    target_row;
	tmcw_pkg::tcol_t    target_col;
	tmcw_pkg::attr_t    cell_color;

	modport source (
		output valid, command, char_code, target_row, target_col, cell_color,
		input  ready
	);
	modport sink (
		input  valid, command, char_code, target_row, target_col, cell_color,
		output ready
	);
endinterface

interface tmcw_res_if;
	logic            valid;
	logic            ready;
	tmcw_pkg::trow_t cursor_row;
	tmcw_pkg::tcol_t cursor_col;
	tmcw_pkg::pos_t  cursor_position;
	tmcw_pkg::cell_t cell_data;
	logic            echo_valid;
	tmcw_pkg::char_t echo_char;

	modport source (
		output valid, cursor_row, cursor_col, cursor_position, cell_data,
			echo_valid, echo_char,
		input  ready
	);
	modport sink (
		input  valid, cursor_row, cursor_col, cursor_position, cell_data,
			echo_valid, echo_char,
		output ready
	);
endinterface

### rtl/core/tmcw_front.sv
// ----------------------------------------------------------------------------
// Console writer front end
// Accepts command words, classifies them and computes target addresses.
// ----------------------------------------------------------------------------
module tmcw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	tmcw_cmd_if.sink              cmd,
	input  tmcw_pkg::queue_stat_t q_stat,
	output logic                  push,
	output tmcw_pkg::op_t         push_op
);

	logic          valid_s1;
	tmcw_pkg::op_t op_s1;
	tmcw_pkg::op_t op_d;
	logic          on_screen;

	assign cmd.ready = !valid_s1 || !q_stat.full;
	assign push      = valid_s1 && !q_stat.full;
	assign push_op   = op_s1;

	always_comb begin
		on_screen  = (int'(cmd.target_row) < tmcw_pkg::ROWS) &&
			(int'(cmd.target_col) < tmcw_pkg::COLUMNS);
		op_d.kind  = tmcw_pkg::OP_NOP;
		op_d.ch    = cmd.char_code;
		op_d.color = cmd.cell_color;
		op_d.addr  = tmcw_pkg::addr_t'(int'(cmd.target_row) * tmcw_pkg::COLUMNS +
			int'(cmd.target_col));
		op_d.echo  = 1'b0;
		case (cmd.command)
			tmcw_pkg::CMD_PUT: begin
				op_d.echo = 1'b1;
				if (cmd.char_code == tmcw_pkg::CH_NEWLINE) begin
					op_d.kind = tmcw_pkg::OP_NEWLINE;
				end else if (cmd.char_code == tmcw_pkg::CH_RETURN) begin
					op_d.kind = tmcw_pkg::OP_RETURN;
				end else begin
					op_d.kind = tmcw_pkg::OP_PUT;
				end
			end
			tmcw_pkg::CMD_BACKSPACE: begin
				op_d.kind = tmcw_pkg::OP_BACKSPACE;
			end
			tmcw_pkg::CMD_CLEAR: begin
				op_d.kind = tmcw_pkg::OP_CLEAR;
			end
			tmcw_pkg::CMD_WRITE_AT: begin
				if (on_screen) begin
					op_d.kind = tmcw_pkg::OP_WRITE;
				end
			end
			tmcw_pkg::CMD_READ: begin
				if (on_screen) begin
					op_d.kind = tmcw_pkg::OP_READ;
				end
			end
			default: begin
				op_d.kind = tmcw_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1 <= op_d;
		end
	end

endmodule

### rtl/core/tmcw_queue.sv
// ----------------------------------------------------------------------------
// Console writer operation queue
// Short FIFO of decoded operations between the front end and the back end.
// ----------------------------------------------------------------------------
module tmcw_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tmcw_pkg::op_t         push_op,
	input  logic                  pop,
	output tmcw_pkg::op_t         head,
	output tmcw_pkg::queue_stat_t q_stat
);

	tmcw_pkg::op_t   entry_q [tmcw_pkg::QUEUE_DEPTH];
	tmcw_pkg::qptr_t wr_ptr_q;
	tmcw_pkg::qptr_t rd_ptr_q;
	tmcw_pkg::qcnt_t count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (count_q == tmcw_pkg::qcnt_t'(tmcw_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = entry_q[rd_ptr_q];

	function automatic tmcw_pkg::qptr_t next_ptr(input tmcw_pkg::qptr_t p);
		if (p == tmcw_pkg::qptr_t'(tmcw_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return tmcw_pkg::qptr_t'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= tmcw_pkg::qcnt_t'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= tmcw_pkg::qcnt_t'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

### rtl/core/tmcw_back.sv
// ----------------------------------------------------------------------------
// Console writer back end
// Owns the screen store and the cursor, and carries out decoded operations.
// ----------------------------------------------------------------------------
module tmcw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmcw_pkg::attr_t       attr,
	input  tmcw_pkg::queue_stat_t q_stat,
	input  tmcw_pkg::op_t         q_head,
	output logic                  pop,
	tmcw_res_if.source            res,
	output tmcw_pkg::back_stat_t  stat
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_FILL
	} state_t;

	// Screen store.
	tmcw_pkg::cell_t mem [tmcw_pkg::CELLS];
	tmcw_pkg::cell_t rdata_q;
	logic            mem_we;
	tmcw_pkg::addr_t mem_waddr;
	tmcw_pkg::cell_t mem_wdata;
	logic            mem_re;
	tmcw_pkg::addr_t mem_raddr;

	state_t          state_q;
	state_t          state_d;
	tmcw_pkg::addr_t ptr_q;
	tmcw_pkg::addr_t ptr_d;
	tmcw_pkg::row_t  row_q;
	tmcw_pkg::row_t  row_d;
	tmcw_pkg::col_t  col_q;
	tmcw_pkg::col_t  col_d;
	logic            copy_v_s1;
	logic            copy_v_d;
	tmcw_pkg::addr_t copy_dst_s1;
	logic            pend_echo_q;
	tmcw_pkg::char_t pend_char_q;

	logic            out_valid_q;
	tmcw_pkg::trow_t out_row_q;
	tmcw_pkg::tcol_t out_col_q;
	tmcw_pkg::pos_t  out_pos_q;
	tmcw_pkg::cell_t out_cell_q;
	logic            out_echo_q;
	tmcw_pkg::char_t out_char_q;

	logic            out_free;
	logic            emit;
	tmcw_pkg::cell_t cell_d;
	logic            echo_d;
	tmcw_pkg::char_t char_d;
	tmcw_pkg::addr_t cur_addr;
	logic            at_last_col;
	logic            at_last_row;

	assign res.valid           = out_valid_q;
	assign res.cursor_row      = out_row_q;
	assign res.cursor_col      = out_col_q;
	assign res.cursor_position = out_pos_q;
	assign res.cell_data       = out_cell_q;
	assign res.echo_valid      = out_echo_q;
	assign res.echo_char       = out_char_q;

	assign stat.init = (state_q == ST_INIT);
	assign stat.busy = (state_q != ST_IDLE);

	// A new operation starts only when the result register is free by the next edge,
	// so a long operation always finds it free when it finishes.
	assign out_free    = !out_valid_q || res.ready;
	assign pop         = (state_q == ST_IDLE) && !q_stat.empty && out_free;
	assign cur_addr    = tmcw_pkg::addr_t'(int'(row_q) * tmcw_pkg::COLUMNS + int'(col_q));
	assign at_last_col = (col_q == tmcw_pkg::col_t'(tmcw_pkg::COLUMNS - 1));
	assign at_last_row = (row_q == tmcw_pkg::row_t'(tmcw_pkg::ROWS - 1));

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		row_d     = row_q;
		col_d     = col_q;
		copy_v_d  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {attr, tmcw_pkg::CH_SPACE};
		mem_re    = 1'b0;
		mem_raddr = q_head.addr;
		emit      = 1'b0;
		cell_d    = '0;
		echo_d    = pend_echo_q;
		char_d    = pend_echo_q ? pend_char_q : '0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = {tmcw_pkg::RESET_ATTR, tmcw_pkg::CH_SPACE};
				ptr_d     = tmcw_pkg::addr_t'(ptr_q + 1'b1);
				if (ptr_q == tmcw_pkg::addr_t'(tmcw_pkg::CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					emit   = 1'b1;
					echo_d = q_head.echo;
					char_d = q_head.echo ? q_head.ch : '0;
					case (q_head.kind)
						tmcw_pkg::OP_PUT: begin
							mem_we    = 1'b1;
							mem_wdata = {attr, q_head.ch};
							if (!at_last_col) begin
								col_d = tmcw_pkg::col_t'(col_q + 1'b1);
							end else begin
								col_d = '0;
								if (at_last_row) begin
									emit    = 1'b0;
									ptr_d   = '0;
									state_d = ST_COPY;
								end else begin
									row_d = tmcw_pkg::row_t'(row_q + 1'b1);
								end
							end
						end
						tmcw_pkg::OP_NEWLINE: begin
							col_d = '0;
							if (at_last_row) begin
								emit    = 1'b0;
								ptr_d   = '0;
								state_d = ST_COPY;
							end else begin
								row_d = tmcw_pkg::row_t'(row_q + 1'b1);
							end
						end
						tmcw_pkg::OP_RETURN: begin
							col_d = '0;
						end
						tmcw_pkg::OP_BACKSPACE: begin
							// The cell before the cursor in linear order is also the last
							// cell of the previous row when the cursor is at a line start.
							if (col_q != '0 || row_q != '0) begin
								mem_we    = 1'b1;
								mem_waddr = tmcw_pkg::addr_t'(cur_addr - 1'b1);
								if (col_q != '0) begin
									col_d = tmcw_pkg::col_t'(col_q - 1'b1);
								end else begin
									row_d = tmcw_pkg::row_t'(row_q - 1'b1);
									col_d = tmcw_pkg::col_t'(tmcw_pkg::COLUMNS - 1);
								end
							end
						end
						tmcw_pkg::OP_CLEAR: begin
							emit    = 1'b0;
							ptr_d   = '0;
							row_d   = '0;
							col_d   = '0;
							state_d = ST_FILL;
						end
						tmcw_pkg::OP_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = q_head.addr;
							mem_wdata = {q_head.color, q_head.ch};
						end
						tmcw_pkg::OP_READ: begin
							emit    = 1'b0;
							mem_re  = 1'b1;
							state_d = ST_READ;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				emit    = 1'b1;
				cell_d  = rdata_q;
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				// Read the cell one row below, write it in the following cycle.
				if (ptr_q != tmcw_pkg::addr_t'(tmcw_pkg::LAST_ROW_BASE)) begin
					mem_re    = 1'b1;
					mem_raddr = tmcw_pkg::addr_t'(ptr_q + tmcw_pkg::COLUMNS);
					ptr_d     = tmcw_pkg::addr_t'(ptr_q + 1'b1);
					copy_v_d  = 1'b1;
				end else begin
					state_d = ST_FILL;
				end
				if (copy_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = copy_dst_s1;
					mem_wdata = rdata_q;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				ptr_d     = tmcw_pkg::addr_t'(ptr_q + 1'b1);
				if (ptr_q == tmcw_pkg::addr_t'(tmcw_pkg::CELLS - 1)) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			copy_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ptr_q       <= ptr_d;
			row_q       <= row_d;
			col_q       <= col_d;
			copy_v_s1   <= copy_v_d;
			copy_dst_s1 <= ptr_q;
			if (pop) begin
				pend_echo_q <= q_head.echo;
				pend_char_q <= q_head.ch;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_row_q   <= tmcw_pkg::trow_t'(row_d);
				out_col_q   <= tmcw_pkg::tcol_t'(col_d);
				out_pos_q   <= tmcw_pkg::pos_t'(int'(row_d) * tmcw_pkg::COLUMNS + int'(col_d));
				out_cell_q  <= cell_d;
				out_echo_q  <= echo_d;
				out_char_q  <= char_d;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

endmodule

### rtl/core/text_mode_console_writer.sv
// ----------------------------------------------------------------------------
// Text mode console writer
// Character-cell console with an 80 x 25 screen store, cursor and echo.
// ----------------------------------------------------------------------------
// Each command word returns exactly one result word carrying the cursor after
// the command. The front end registers and classifies one command per cycle
// while the queue has room and hands it through a two-entry queue to the back
// end, which owns the screen store (one write and one read per cycle) and the
// cursor. In the back end a printable character, carriage return, backspace,
// write-at or an unused command is carried out in the cycle that takes it, a
// read-cell goes through a registered memory read, and clear blanks the store
// one cell per cycle after the cycle that takes the command. A character or
// newline that moves past the last row scrolls: a copy pass moves every row up
// by one and the bottom row is then blanked. After reset the back end runs a
// clearing pass that fills the store with spaces in attribute 0x0F; command
// words are queued but not carried out until it ends, while attribute writes
// are taken at once. A command word is registered in the front end and then in
// the queue, and its result in the result register. The attribute register
// must be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "text_mode_console_writer_macros.svh"

module text_mode_console_writer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  tmcw_pkg::attr_t cfg_wr_data,
	tmcw_cmd_if.sink        cmd,
	tmcw_res_if.source      res
);

	// Attribute used by put-char, backspace, clear and scroll.
	tmcw_pkg::attr_t       attr_q;

	// Front end to queue, queue to back end.
	logic                  push;
	tmcw_pkg::op_t         push_op;
	logic                  pop;
	tmcw_pkg::op_t         q_head;
	tmcw_pkg::queue_stat_t q_stat;
	tmcw_pkg::back_stat_t  back_stat;

	// Conditions watched by the checks at the end of the module.
	logic                  pos_ok;
	logic                  no_echo;
	logic                  init_or_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmcw_pkg::RESET_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	// Classifies each command word and computes its store address.
	tmcw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_stat  (q_stat),
		.push    (push),
		.push_op (push_op)
	);

	// Lets the front end keep accepting while the back end is in a long pass.
	tmcw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (q_head),
		.q_stat  (q_stat)
	);

	// Carries out operations on the screen store and the cursor.
	tmcw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.attr   (attr_q),
		.q_stat (q_stat),
		.q_head (q_head),
		.pop    (pop),
		.res    (res),
		.stat   (back_stat)
	);

	assign pos_ok = (res.cursor_position == tmcw_pkg::pos_t'(int'(res.cursor_row) *
		tmcw_pkg::COLUMNS + int'(res.cursor_col)));
	assign no_echo      = res.valid && !res.echo_valid;
	assign init_or_idle = back_stat.init || !back_stat.busy;

	// No result may appear while the clearing pass after reset is still running.
	`TMCW_ASSERT_IMPLY(a_quiet_in_init, clk, arst_n, back_stat.init, !res.valid, "result in init")

	// The reported linear offset must agree with the reported row and column.
	`TMCW_ASSERT_IMPLY(a_pos_matches, clk, arst_n, res.valid, pos_ok, "offset mismatch")

	// A result without an echo carries a zero echo character.
	`TMCW_ASSERT_IMPLY(a_echo_zero, clk, arst_n, no_echo, res.echo_char == '0, "stray echo char")

	// The clearing pass hands over straight to the idle state.
	`TMCW_ASSERT_NEXT(a_init_to_idle, clk, arst_n, back_stat.init, init_or_idle, "init not to idle")

endmodule
